// ----- hw/rtl/pvmc_pkg.sv -----
// Shared types and constants for the priority vector magnitude clamp.
// Depends on nothing; every other file in hw/rtl refers to it by scoped names.
package pvmc_pkg;

  localparam int DATA_W    = 32;
  localparam int LIMIT_W   = 31;
  localparam int FRAC_BITS = 16;
  localparam int UNIT_BITS = 30;

  // Closeness threshold of 0.001 in raw fixed point, rounded.
  localparam int EPS_RAW = ((2 ** FRAC_BITS) + 500) / 1000;
  localparam logic [31:0] EPS_SQ = 32'(EPS_RAW * EPS_RAW);

  localparam int RAD_W  = 2 * DATA_W;
  localparam int ROOT_W = RAD_W / 2;
  localparam int NUM_W  = DATA_W + LIMIT_W;
  localparam int DEN_W  = ROOT_W;
  localparam int QUO_W  = LIMIT_W;

  typedef enum logic [2:0] {
    BR_FIT  = 3'd0,
    BR_SAT  = 3'd1,
    BR_EQ   = 3'd2,
    BR_ZERO = 3'd3,
    BR_QUAD = 3'd4
  } branch_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] first_x;
    logic signed [DATA_W-1:0] first_y;
    logic signed [DATA_W-1:0] second_x;
    logic signed [DATA_W-1:0] second_y;
    logic [LIMIT_W-1:0]       limit;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_x;
    logic signed [DATA_W-1:0] result_y;
    branch_t                  branch;
  } result_t;

endpackage

// ----- hw/rtl/priority_vector_magnitude_clamp_core.sv -----
// Top level of the priority vector magnitude clamp: branch selection, scaling and
// the quadratic solve. Depends on pvmc_pkg, pvmc_sqrt_pipe and pvmc_div_pipe.
//
//   channel   ports                                   payload
//   input     item_valid, item_ready, item            pvmc_pkg::item_t
//   output    result_valid, result_ready, result      pvmc_pkg::result_t
//
// One transaction enters per cycle while item_ready is high; the two 32-stage
// square-root pipelines and the 31-stage divider lie in series.
// Reset clears only valid bits; the datapath needs no clearing.
// A skid register behind the output register lets the pipeline take one more
// transaction after the output stalls; item_ready then drops until the skid drains.
module priority_vector_magnitude_clamp_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  pvmc_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_ready,
  output pvmc_pkg::result_t   result
);

  localparam int DW = pvmc_pkg::DATA_W;
  localparam int LW = pvmc_pkg::LIMIT_W;
  localparam int MW = DW + 2;
  localparam int PW = DW + MW + 1;
  localparam int SQ = pvmc_pkg::ROOT_W;
  localparam int DQ = pvmc_pkg::QUO_W;
  localparam int NW = pvmc_pkg::NUM_W;

  typedef struct packed {
    logic signed [DW-1:0] x0, y0, x1, y1;
    logic [LW-1:0]        lim;
    logic signed [DW:0]   sx, sy, dx, dy;
  } st1_t;

  typedef struct packed {
    logic signed [DW-1:0] x0, y0, x1, y1;
    logic [LW-1:0]        lim;
    logic signed [DW:0]   sx, sy;
    logic [2*DW+1:0]      qsx, qsy, qdx, qdy;
    logic [2*DW-1:0]      qx0, qy0, qx1, qy1;
    logic [2*LW-1:0]      lim_sq;
  } st2_t;

  typedef struct packed {
    logic signed [DW-1:0] x0, y0, x1, y1;
    logic [LW-1:0]        lim;
    logic signed [DW:0]   sx, sy;
    logic [2*DW+2:0]      sum_sq, dif_sq;
    logic [2*DW-1:0]      n0_sq, n1_sq;
    logic [2*LW-1:0]      lim_sq;
  } st3_t;

  typedef struct packed {
    pvmc_pkg::branch_t    br;
    logic signed [DW-1:0] sel_x, sel_y;
    logic [LW-1:0]        k;
    logic [2*DW-1:0]      rad;
    logic signed [DW-1:0] x0, y0;
    logic [2*DW-1:0]      gap;
    logic signed [DW:0]   sx, sy;
  } st4_t;

  typedef struct packed {
    pvmc_pkg::branch_t    br;
    logic                 neg_x, neg_y;
    logic [NW-1:0]        num_x, num_y;
    logic signed [DW-1:0] x0, y0;
    logic [2*DW-1:0]      gap;
    logic signed [DW:0]   sx, sy;
  } sidea_t;

  typedef struct packed {
    pvmc_pkg::branch_t    br;
    logic                 neg_x, neg_y, den_zero;
    logic signed [DW-1:0] x0, y0;
    logic [2*DW-1:0]      gap;
    logic signed [DW:0]   sx, sy;
  } sideb_t;

  typedef struct packed {
    pvmc_pkg::branch_t    br;
    logic signed [DW-1:0] ux, uy, x0, y0;
    logic [2*DW-1:0]      gap;
    logic signed [DW:0]   sx, sy;
  } sta_t;

  typedef struct packed {
    pvmc_pkg::branch_t      br;
    logic signed [DW-1:0]   ux, uy;
    logic signed [2*DW-1:0] pxx, pyy;
    logic signed [DW-1:0]   x0, y0;
    logic [2*DW-1:0]        gap;
    logic signed [DW:0]     sx, sy;
  } stb_t;

  typedef struct packed {
    pvmc_pkg::branch_t    br;
    logic signed [DW-1:0] ux, uy;
    logic signed [MW-1:0] m;
    logic signed [DW-1:0] x0, y0;
    logic [2*DW-1:0]      gap;
    logic signed [DW:0]   sx, sy;
  } stc_t;

  typedef struct packed {
    pvmc_pkg::branch_t    br;
    logic signed [DW-1:0] ux, uy;
    logic signed [MW-1:0] m;
    logic [2*DW-1:0]      m_sq;
    logic signed [DW-1:0] x0, y0;
    logic [2*DW-1:0]      gap;
    logic signed [DW:0]   sx, sy;
  } std_t;

  typedef struct packed {
    pvmc_pkg::branch_t    br;
    logic signed [DW-1:0] ux, uy;
    logic signed [MW-1:0] m;
    logic signed [DW-1:0] x0, y0;
    logic signed [DW:0]   sx, sy;
  } sidec_t;

  typedef struct packed {
    pvmc_pkg::branch_t    br;
    logic signed [DW-1:0] ux, uy;
    logic [MW-1:0]        s;
    logic signed [DW-1:0] x0, y0;
    logic signed [DW:0]   sx, sy;
  } stf_t;

  typedef struct packed {
    pvmc_pkg::branch_t    br;
    logic signed [DW-1:0] ux, uy;
    logic signed [PW-1:0] tx, ty;
    logic signed [DW-1:0] x0, y0;
    logic signed [DW:0]   sx, sy;
  } stg_t;

  function automatic logic [DW-1:0] mag_d(logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(~v + 1'b1) : DW'(v);
  endfunction

  function automatic logic [DW:0] mag_s(logic signed [DW:0] v);
    return v[DW] ? (DW+1)'(~v + 1'b1) : (DW+1)'(v);
  endfunction

  // Clamp a wide signed value to the signed output range.
  function automatic logic [DW-1:0] sat_w(logic signed [PW:0] v);
    logic [PW-DW+1:0] top;
    top = v[PW:DW-1];
    if (top == '0 || top == '1) begin
      return v[DW-1:0];
    end else if (v[PW]) begin
      return {1'b1, {(DW-1){1'b0}}};
    end else begin
      return {1'b0, {(DW-1){1'b1}}};
    end
  endfunction

  // Round toward zero when dropping the unit-vector fraction bits.
  function automatic logic signed [PW:0] trunc_unit(logic signed [PW:0] v);
    logic signed [PW:0] acc;
    acc = v;
    if (v[PW]) begin
      acc = v + (PW+1)'(((PW+1)'(1) << pvmc_pkg::UNIT_BITS) - 1'b1);
    end
    return acc >>> pvmc_pkg::UNIT_BITS;
  endfunction

  logic en;
  logic skid_v;
  pvmc_pkg::result_t skid;

  logic p1_v, p2_v, p3_v, p4_v, p5_v;
  logic pa_v, pb_v, pc_v, pd_v, pe_v, pf_v, pg_v;
  logic [SQ-1:0] dla_v, dlc_v;
  logic [DQ-1:0] dlb_v;

  st1_t p1, p1_next;
  st2_t p2, p2_next;
  st3_t p3, p3_next;
  st4_t p4, p4_next;
  sidea_t p5, p5_next;
  logic [2*DW-1:0] p5_rad;
  sidea_t dla [SQ];
  sideb_t dlb [DQ];
  sideb_t dlb_in;
  sta_t pa, pa_next;
  stb_t pb, pb_next;
  stc_t pc, pc_next;
  std_t pd, pd_next;
  sidec_t pe, pe_next;
  logic [2*DW-1:0] pe_rad;
  sidec_t dlc [SQ];
  stf_t pf, pf_next;
  stg_t pg, pg_next;
  pvmc_pkg::result_t fin;

  logic [SQ-1:0] root1, root2;
  logic [DQ-1:0] quo_x, quo_y;

  assign en         = !skid_v;
  assign item_ready = en;

  // Sums and differences of the two vectors.
  always_comb begin
    p1_next.x0  = item.first_x;
    p1_next.y0  = item.first_y;
    p1_next.x1  = item.second_x;
    p1_next.y1  = item.second_y;
    p1_next.lim = item.limit;
    p1_next.sx  = {item.first_x[DW-1], item.first_x} + {item.second_x[DW-1], item.second_x};
    p1_next.sy  = {item.first_y[DW-1], item.first_y} + {item.second_y[DW-1], item.second_y};
    p1_next.dx  = {item.second_x[DW-1], item.second_x} - {item.first_x[DW-1], item.first_x};
    p1_next.dy  = {item.second_y[DW-1], item.second_y} - {item.first_y[DW-1], item.first_y};
  end

  // Component squares, one multiplier each.
  always_comb begin
    p2_next.x0     = p1.x0;
    p2_next.y0     = p1.y0;
    p2_next.x1     = p1.x1;
    p2_next.y1     = p1.y1;
    p2_next.lim    = p1.lim;
    p2_next.sx     = p1.sx;
    p2_next.sy     = p1.sy;
    p2_next.qsx    = (2*DW+2)'(mag_s(p1.sx)) * (2*DW+2)'(mag_s(p1.sx));
    p2_next.qsy    = (2*DW+2)'(mag_s(p1.sy)) * (2*DW+2)'(mag_s(p1.sy));
    p2_next.qdx    = (2*DW+2)'(mag_s(p1.dx)) * (2*DW+2)'(mag_s(p1.dx));
    p2_next.qdy    = (2*DW+2)'(mag_s(p1.dy)) * (2*DW+2)'(mag_s(p1.dy));
    p2_next.qx0    = (2*DW)'(mag_d(p1.x0)) * (2*DW)'(mag_d(p1.x0));
    p2_next.qy0    = (2*DW)'(mag_d(p1.y0)) * (2*DW)'(mag_d(p1.y0));
    p2_next.qx1    = (2*DW)'(mag_d(p1.x1)) * (2*DW)'(mag_d(p1.x1));
    p2_next.qy1    = (2*DW)'(mag_d(p1.y1)) * (2*DW)'(mag_d(p1.y1));
    p2_next.lim_sq = (2*LW)'(p1.lim) * (2*LW)'(p1.lim);
  end

  // Squared lengths.
  always_comb begin
    p3_next.x0     = p2.x0;
    p3_next.y0     = p2.y0;
    p3_next.x1     = p2.x1;
    p3_next.y1     = p2.y1;
    p3_next.lim    = p2.lim;
    p3_next.sx     = p2.sx;
    p3_next.sy     = p2.sy;
    p3_next.sum_sq = (2*DW+3)'(p2.qsx) + (2*DW+3)'(p2.qsy);
    p3_next.dif_sq = (2*DW+3)'(p2.qdx) + (2*DW+3)'(p2.qdy);
    p3_next.n0_sq  = p2.qx0 + p2.qy0;
    p3_next.n1_sq  = p2.qx1 + p2.qy1;
    p3_next.lim_sq = p2.lim_sq;
  end

  // Branch decision and choice of the vector to normalize.
  always_comb begin
    priority if (p3.sum_sq <= (2*DW+3)'(p3.lim_sq)) begin
      p4_next.br = pvmc_pkg::BR_FIT;
    end else if (p3.n0_sq >= (2*DW)'(p3.lim_sq)) begin
      p4_next.br = pvmc_pkg::BR_SAT;
    end else if (p3.dif_sq < (2*DW+3)'(pvmc_pkg::EPS_SQ)) begin
      p4_next.br = pvmc_pkg::BR_EQ;
    end else if (p3.n0_sq < (2*DW)'(pvmc_pkg::EPS_SQ)) begin
      p4_next.br = pvmc_pkg::BR_ZERO;
    end else begin
      p4_next.br = pvmc_pkg::BR_QUAD;
    end
    if (p4_next.br == pvmc_pkg::BR_SAT || p4_next.br == pvmc_pkg::BR_EQ) begin
      p4_next.sel_x = p3.x0;
      p4_next.sel_y = p3.y0;
      p4_next.rad   = p3.n0_sq;
    end else begin
      p4_next.sel_x = p3.x1;
      p4_next.sel_y = p3.y1;
      p4_next.rad   = p3.n1_sq;
    end
    // The quadratic case normalizes to a unit vector with UNIT_BITS fraction bits.
    p4_next.k   = (p4_next.br == pvmc_pkg::BR_QUAD) ? (LW'(1) << pvmc_pkg::UNIT_BITS) : p3.lim;
    p4_next.x0  = p3.x0;
    p4_next.y0  = p3.y0;
    p4_next.gap = (2*DW)'(p3.lim_sq) - p3.n0_sq;
    p4_next.sx  = p3.sx;
    p4_next.sy  = p3.sy;
  end

  // Dividends for scaling: magnitude times the target length.
  always_comb begin
    p5_next.br    = p4.br;
    p5_next.neg_x = p4.sel_x[DW-1];
    p5_next.neg_y = p4.sel_y[DW-1];
    p5_next.num_x = NW'(mag_d(p4.sel_x)) * NW'(p4.k);
    p5_next.num_y = NW'(mag_d(p4.sel_y)) * NW'(p4.k);
    p5_next.x0    = p4.x0;
    p5_next.y0    = p4.y0;
    p5_next.gap   = p4.gap;
    p5_next.sx    = p4.sx;
    p5_next.sy    = p4.sy;
  end

  pvmc_sqrt_pipe u_sqrt_len (
    .clk  (clk),
    .en   (en),
    .rad  (p5_rad),
    .root (root1)
  );

  always_comb begin
    dlb_in.br       = dla[SQ-1].br;
    dlb_in.neg_x    = dla[SQ-1].neg_x;
    dlb_in.neg_y    = dla[SQ-1].neg_y;
    dlb_in.den_zero = (root1 == '0);
    dlb_in.x0       = dla[SQ-1].x0;
    dlb_in.y0       = dla[SQ-1].y0;
    dlb_in.gap      = dla[SQ-1].gap;
    dlb_in.sx       = dla[SQ-1].sx;
    dlb_in.sy       = dla[SQ-1].sy;
  end

  pvmc_div_pipe u_div (
    .clk   (clk),
    .en    (en),
    .num_x (dla[SQ-1].num_x),
    .num_y (dla[SQ-1].num_y),
    .den   (root1),
    .quo_x (quo_x),
    .quo_y (quo_y)
  );

  // Signed scaled vector; a zero length yields zero.
  always_comb begin
    logic [DW-1:0] qx;
    logic [DW-1:0] qy;
    qx         = DW'(quo_x);
    qy         = DW'(quo_y);
    pa_next.br = dlb[DQ-1].br;
    pa_next.ux = dlb[DQ-1].den_zero ? '0 : (dlb[DQ-1].neg_x ? DW'(~qx + 1'b1) : qx);
    pa_next.uy = dlb[DQ-1].den_zero ? '0 : (dlb[DQ-1].neg_y ? DW'(~qy + 1'b1) : qy);
    pa_next.x0  = dlb[DQ-1].x0;
    pa_next.y0  = dlb[DQ-1].y0;
    pa_next.gap = dlb[DQ-1].gap;
    pa_next.sx  = dlb[DQ-1].sx;
    pa_next.sy  = dlb[DQ-1].sy;
  end

  always_comb begin
    pb_next.br  = pa.br;
    pb_next.ux  = pa.ux;
    pb_next.uy  = pa.uy;
    pb_next.pxx = (2*DW)'(pa.ux) * (2*DW)'(pa.x0);
    pb_next.pyy = (2*DW)'(pa.uy) * (2*DW)'(pa.y0);
    pb_next.x0  = pa.x0;
    pb_next.y0  = pa.y0;
    pb_next.gap = pa.gap;
    pb_next.sx  = pa.sx;
    pb_next.sy  = pa.sy;
  end

  // Projection of the first vector on the unit direction.
  always_comb begin
    logic signed [2*DW-1:0] dot;
    logic signed [PW:0]     dq;
    dot        = pb.pxx + pb.pyy;
    dq         = trunc_unit((PW+1)'(dot));
    pc_next.br  = pb.br;
    pc_next.ux  = pb.ux;
    pc_next.uy  = pb.uy;
    pc_next.m   = MW'(dq);
    pc_next.x0  = pb.x0;
    pc_next.y0  = pb.y0;
    pc_next.gap = pb.gap;
    pc_next.sx  = pb.sx;
    pc_next.sy  = pb.sy;
  end

  always_comb begin
    logic [MW-1:0]   am;
    logic [2*MW-1:0] sq;
    am   = pc.m[MW-1] ? MW'(~pc.m + 1'b1) : MW'(pc.m);
    sq   = (2*MW)'(am) * (2*MW)'(am);
    pd_next.br   = pc.br;
    pd_next.ux   = pc.ux;
    pd_next.uy   = pc.uy;
    pd_next.m    = pc.m;
    pd_next.m_sq = sq[2*DW-1:0];
    pd_next.x0   = pc.x0;
    pd_next.y0   = pc.y0;
    pd_next.gap  = pc.gap;
    pd_next.sx   = pc.sx;
    pd_next.sy   = pc.sy;
  end

  always_comb begin
    pe_next.br = pd.br;
    pe_next.ux = pd.ux;
    pe_next.uy = pd.uy;
    pe_next.m  = pd.m;
    pe_next.x0 = pd.x0;
    pe_next.y0 = pd.y0;
    pe_next.sx = pd.sx;
    pe_next.sy = pd.sy;
  end

  pvmc_sqrt_pipe u_sqrt_disc (
    .clk  (clk),
    .en   (en),
    .rad  (pe_rad),
    .root (root2)
  );

  // Step length along the unit direction, never negative.
  always_comb begin
    logic signed [MW:0] dd;
    dd = $signed({3'b000, root2}) - (MW+1)'(dlc[SQ-1].m);
    pf_next.br = dlc[SQ-1].br;
    pf_next.ux = dlc[SQ-1].ux;
    pf_next.uy = dlc[SQ-1].uy;
    pf_next.s  = dd[MW] ? '0 : dd[MW-1:0];
    pf_next.x0 = dlc[SQ-1].x0;
    pf_next.y0 = dlc[SQ-1].y0;
    pf_next.sx = dlc[SQ-1].sx;
    pf_next.sy = dlc[SQ-1].sy;
  end

  always_comb begin
    pg_next.br = pf.br;
    pg_next.ux = pf.ux;
    pg_next.uy = pf.uy;
    pg_next.tx = PW'(pf.ux) * PW'($signed({1'b0, pf.s}));
    pg_next.ty = PW'(pf.uy) * PW'($signed({1'b0, pf.s}));
    pg_next.x0 = pf.x0;
    pg_next.y0 = pf.y0;
    pg_next.sx = pf.sx;
    pg_next.sy = pf.sy;
  end

  always_comb begin
    logic signed [PW:0] rx;
    logic signed [PW:0] ry;
    rx = (PW+1)'(pg.x0) + trunc_unit((PW+1)'(pg.tx));
    ry = (PW+1)'(pg.y0) + trunc_unit((PW+1)'(pg.ty));
    fin.branch = pg.br;
    unique case (pg.br)
      pvmc_pkg::BR_FIT: begin
        fin.result_x = sat_w((PW+1)'(pg.sx));
        fin.result_y = sat_w((PW+1)'(pg.sy));
      end
      pvmc_pkg::BR_SAT, pvmc_pkg::BR_EQ, pvmc_pkg::BR_ZERO: begin
        fin.result_x = pg.ux;
        fin.result_y = pg.uy;
      end
      default: begin
        fin.result_x = sat_w(rx);
        fin.result_y = sat_w(ry);
      end
    endcase
  end

  // Valid bits travel with the data and freeze together with it.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v  <= 1'b0;
      p2_v  <= 1'b0;
      p3_v  <= 1'b0;
      p4_v  <= 1'b0;
      p5_v  <= 1'b0;
      dla_v <= '0;
      dlb_v <= '0;
      pa_v  <= 1'b0;
      pb_v  <= 1'b0;
      pc_v  <= 1'b0;
      pd_v  <= 1'b0;
      pe_v  <= 1'b0;
      dlc_v <= '0;
      pf_v  <= 1'b0;
      pg_v  <= 1'b0;
    end else if (en) begin
      p1_v  <= item_valid;
      p2_v  <= p1_v;
      p3_v  <= p2_v;
      p4_v  <= p3_v;
      p5_v  <= p4_v;
      dla_v <= {dla_v[SQ-2:0], p5_v};
      dlb_v <= {dlb_v[DQ-2:0], dla_v[SQ-1]};
      pa_v  <= dlb_v[DQ-1];
      pb_v  <= pa_v;
      pc_v  <= pb_v;
      pd_v  <= pc_v;
      pe_v  <= pd_v;
      dlc_v <= {dlc_v[SQ-2:0], pe_v};
      pf_v  <= dlc_v[SQ-1];
      pg_v  <= pf_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1     <= p1_next;
      p2     <= p2_next;
      p3     <= p3_next;
      p4     <= p4_next;
      p5     <= p5_next;
      p5_rad <= p4.rad;
      dla[0] <= p5;
      for (int k = 1; k < SQ; k++) begin
        dla[k] <= dla[k-1];
      end
      dlb[0] <= dlb_in;
      for (int k = 1; k < DQ; k++) begin
        dlb[k] <= dlb[k-1];
      end
      pa     <= pa_next;
      pb     <= pb_next;
      pc     <= pc_next;
      pd     <= pd_next;
      pe     <= pe_next;
      pe_rad <= pd.m_sq + pd.gap;
      dlc[0] <= pe;
      for (int k = 1; k < SQ; k++) begin
        dlc[k] <= dlc[k-1];
      end
      pf     <= pf_next;
      pg     <= pg_next;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_v       <= 1'b0;
    end else if (en) begin
      if (pg_v) begin
        if (!result_valid || result_ready) begin
          result_valid <= 1'b1;
        end else begin
          skid_v <= 1'b1;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end else if (result_ready) begin
      skid_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (pg_v) begin
        if (!result_valid || result_ready) begin
          result <= fin;
        end else begin
          skid <= fin;
        end
      end
    end else if (result_ready) begin
      result <= skid;
    end
  end

endmodule

// ----- hw/rtl/pvmc_sqrt_pipe.sv -----
// Pipelined integer square root, one root bit per register stage.
// Depends on pvmc_pkg for the radicand and root widths.
module pvmc_sqrt_pipe (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pvmc_pkg::RAD_W-1:0]    rad,
  output logic [pvmc_pkg::ROOT_W-1:0]   root
);

  localparam int REM_W = pvmc_pkg::ROOT_W + 2;

  typedef struct packed {
    logic [pvmc_pkg::RAD_W-1:0]  rad;
    logic [REM_W-1:0]            rem;
    logic [pvmc_pkg::ROOT_W-1:0] root;
  } step_t;

  // Bring down two radicand bits and try to set the next root bit.
  function automatic step_t sqrt_step(step_t s);
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    step_t            n;
    cur   = {s.rem, s.rad[pvmc_pkg::RAD_W-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    n.rad = s.rad << 2;
    if (cur >= trial) begin
      n.rem  = REM_W'(cur - trial);
      n.root = {s.root[pvmc_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = cur[REM_W-1:0];
      n.root = {s.root[pvmc_pkg::ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  step_t st [pvmc_pkg::ROOT_W];
  step_t first;

  always_comb begin
    first.rad  = rad;
    first.rem  = '0;
    first.root = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= sqrt_step(first);
      for (int k = 1; k < pvmc_pkg::ROOT_W; k++) begin
        st[k] <= sqrt_step(st[k-1]);
      end
    end
  end

  assign root = st[pvmc_pkg::ROOT_W-1].root;

endmodule

// ----- hw/rtl/pvmc_div_pipe.sv -----
// Two-lane pipelined restoring divider with a shared divisor, one quotient bit per stage.
// Depends on pvmc_pkg for the dividend, divisor and quotient widths.
module pvmc_div_pipe (
  input  logic                         clk,
  input  logic                         en,
  input  logic [pvmc_pkg::NUM_W-1:0]   num_x,
  input  logic [pvmc_pkg::NUM_W-1:0]   num_y,
  input  logic [pvmc_pkg::DEN_W-1:0]   den,
  output logic [pvmc_pkg::QUO_W-1:0]   quo_x,
  output logic [pvmc_pkg::QUO_W-1:0]   quo_y
);

  typedef struct packed {
    logic [pvmc_pkg::NUM_W-1:0] rem_x;
    logic [pvmc_pkg::NUM_W-1:0] rem_y;
    logic [pvmc_pkg::QUO_W-1:0] q_x;
    logic [pvmc_pkg::QUO_W-1:0] q_y;
    logic [pvmc_pkg::DEN_W-1:0] den;
  } step_t;

  // Decide quotient bit i of both lanes against the divisor shifted up by i.
  function automatic step_t div_step(step_t s, int i);
    logic [pvmc_pkg::NUM_W-1:0] dsh;
    step_t                      n;
    dsh   = pvmc_pkg::NUM_W'(s.den) << i;
    n.den = s.den;
    if (s.rem_x >= dsh) begin
      n.rem_x = s.rem_x - dsh;
      n.q_x   = {s.q_x[pvmc_pkg::QUO_W-2:0], 1'b1};
    end else begin
      n.rem_x = s.rem_x;
      n.q_x   = {s.q_x[pvmc_pkg::QUO_W-2:0], 1'b0};
    end
    if (s.rem_y >= dsh) begin
      n.rem_y = s.rem_y - dsh;
      n.q_y   = {s.q_y[pvmc_pkg::QUO_W-2:0], 1'b1};
    end else begin
      n.rem_y = s.rem_y;
      n.q_y   = {s.q_y[pvmc_pkg::QUO_W-2:0], 1'b0};
    end
    return n;
  endfunction

  step_t st [pvmc_pkg::QUO_W];
  step_t first;

  always_comb begin
    first.rem_x = num_x;
    first.rem_y = num_y;
    first.q_x   = '0;
    first.q_y   = '0;
    first.den   = den;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= div_step(first, pvmc_pkg::QUO_W - 1);
      for (int k = 1; k < pvmc_pkg::QUO_W; k++) begin
        st[k] <= div_step(st[k-1], pvmc_pkg::QUO_W - 1 - k);
      end
    end
  end

  assign quo_x = st[pvmc_pkg::QUO_W-1].q_x;
  assign quo_y = st[pvmc_pkg::QUO_W-1].q_y;

endmodule

// ----- bench/pvmc_checker.sv -----
// Scoreboard for the priority vector magnitude clamp: predicts each result from the
// accepted input transaction and compares it with the block's output. Depends on pvmc_pkg.
module pvmc_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  pvmc_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  pvmc_pkg::result_t result,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint UNIT_ONE = longint'(1) <<< pvmc_pkg::UNIT_BITS;

  pvmc_pkg::result_t clamp_q[$];

  function automatic logic [63:0] abs64(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [127:0] sq_wide(longint x, longint y);
    logic [127:0] ax, ay;
    ax = abs64(x);
    ay = abs64(y);
    return ax * ax + ay * ay;
  endfunction

  function automatic logic [63:0] sq_narrow(longint x, longint y);
    return abs64(x) * abs64(x) + abs64(y) * abs64(y);
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Stretch a vector to the limit; a zero-length vector stays zero.
  function automatic void scale_vec(longint x, longint y, longint lim,
                                    output longint rx, output longint ry);
    longint n;
    n = $signed(root64(sq_narrow(x, y)));
    if (n == 0) begin
      rx = 0;
      ry = 0;
    end else begin
      rx = (x * lim) / n;
      ry = (y * lim) / n;
    end
  endfunction

  function automatic pvmc_pkg::result_t clamp_predict(pvmc_pkg::item_t it);
    longint x0, y0, x1, y1, lim, rx, ry, n1, ux, uy, m, s;
    logic [63:0] lim_sq, eps_sq, n0_sq, d;
    pvmc_pkg::result_t r;
    x0 = longint'(it.first_x);
    y0 = longint'(it.first_y);
    x1 = longint'(it.second_x);
    y1 = longint'(it.second_y);
    lim = longint'({1'b0, it.limit});
    lim_sq = 64'(lim) * 64'(lim);
    eps_sq = 64'(pvmc_pkg::EPS_RAW) * 64'(pvmc_pkg::EPS_RAW);
    n0_sq = sq_narrow(x0, y0);
    if (sq_wide(x0 + x1, y0 + y1) <= {64'd0, lim_sq}) begin
      r.branch = pvmc_pkg::BR_FIT;
      rx = x0 + x1;
      ry = y0 + y1;
    end else if (n0_sq >= lim_sq) begin
      r.branch = pvmc_pkg::BR_SAT;
      scale_vec(x0, y0, lim, rx, ry);
    end else if (sq_wide(x1 - x0, y1 - y0) < {64'd0, eps_sq}) begin
      r.branch = pvmc_pkg::BR_EQ;
      scale_vec(x0, y0, lim, rx, ry);
    end else if (n0_sq < eps_sq) begin
      r.branch = pvmc_pkg::BR_ZERO;
      scale_vec(x1, y1, lim, rx, ry);
    end else begin
      r.branch = pvmc_pkg::BR_QUAD;
      n1 = $signed(root64(sq_narrow(x1, y1)));
      ux = 0;
      uy = 0;
      if (n1 != 0) begin
        ux = (x1 * UNIT_ONE) / n1;
        uy = (y1 * UNIT_ONE) / n1;
      end
      // Projection of the first vector onto the unit direction of the second.
      m = (ux * x0 + uy * y0) / UNIT_ONE;
      d = abs64(m) * abs64(m) + (lim_sq - n0_sq);
      s = $signed(root64(d)) - m;
      if (s < 0) s = 0;
      rx = x0 + (ux * s) / UNIT_ONE;
      ry = y0 + (uy * s) / UNIT_ONE;
    end
    r.result_x = sat32(rx);
    r.result_y = sat32(ry);
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  assign pending = clamp_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    pvmc_pkg::result_t want;
    if (!rst) begin
      if (item_valid && item_ready) clamp_q.push_back(clamp_predict(item));
      if (result_valid && result_ready) begin
        if (clamp_q.size() == 0) begin
          report("unexpected transaction, branch", result.branch, -1);
        end else begin
          want = clamp_q.pop_front();
          if (result.result_x !== want.result_x)
            report("result_x", result.result_x, want.result_x);
          if (result.result_y !== want.result_y)
            report("result_y", result.result_y, want.result_y);
          if (result.branch !== want.branch)
            report("branch", result.branch, want.branch);
        end
      end
    end
  end

endmodule

// ----- bench/priority_vector_magnitude_clamp_core_tb.sv -----
// Top of the clamp testbench: clock, reset, stimulus, stall patterns and verdict.
// Depends on pvmc_pkg, pvmc_checker and the priority_vector_magnitude_clamp_core RTL.
module priority_vector_magnitude_clamp_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM  = 1800;
  localparam int STALL_LIMIT = 20000;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_ready;
  pvmc_pkg::item_t   item;
  logic              result_valid;
  logic              result_ready;
  pvmc_pkg::result_t result;
  int                errors;
  int                pending;
  logic              calm;
  int                idle_cycles;

  priority_vector_magnitude_clamp_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  pvmc_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .errors       (errors),
    .pending      (pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic pvmc_pkg::item_t mk_item(int x0, int y0, int x1, int y1, int lim);
    pvmc_pkg::item_t it;
    it.first_x  = x0;
    it.first_y  = y0;
    it.second_x = x1;
    it.second_y = y1;
    it.limit    = lim[30:0];
    return it;
  endfunction

  // Signed value whose magnitude is below 2^bits; for 31 or more bits, any 32-bit value.
  function automatic int rnd_mag(int bits);
    int v;
    v = (bits >= 31) ? $urandom : int'($urandom & ((32'd1 << bits) - 1));
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic pvmc_pkg::item_t rnd_item();
    int bits, x0, y0, x1, y1, lim;
    bits = $urandom_range(31, 4);
    x0 = rnd_mag(bits);
    y0 = rnd_mag(bits);
    x1 = rnd_mag(bits);
    y1 = rnd_mag(bits);
    case ($urandom_range(5))
      0: begin
        x1 = x0 + rnd_mag(5);
        y1 = y0 + rnd_mag(5);
      end
      1: begin
        x0 = rnd_mag(6);
        y0 = rnd_mag(6);
      end
      2: begin
        x0 = $urandom;
        y0 = $urandom;
        x1 = $urandom;
        y1 = $urandom;
      end
      default: ;
    endcase
    if ($urandom_range(3) == 0) lim = $urandom;
    else lim = $urandom & ((32'd1 << (bits < 31 ? bits + 1 : 31)) - 1);
    return mk_item(x0, y0, x1, y1, lim);
  endfunction

  task automatic send(pvmc_pkg::item_t it, logic may_idle);
    logic ok;
    if (may_idle && !calm) begin
      while ($urandom_range(99) < 24) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item <= it;
    item_valid <= 1'b1;
    do begin
      @(negedge clk);
      ok = item_ready;
      @(posedge clk);
    end while (!ok);
  endtask

  // Receiver stalls at random except during the calm stretch.
  always @(posedge clk) begin
    if (rst) result_ready <= 1'b0;
    else result_ready <= calm || ($urandom_range(99) >= 24);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL priority_vector_magnitude_clamp_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pvmc_pkg::item_t directed[$];
    rst = 1'b1;
    calm = 1'b0;
    item_valid = 1'b0;
    item = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    directed.push_back(mk_item(0, 0, 0, 0, 0));
    directed.push_back(mk_item(65536, 0, 0, 0, 0));
    directed.push_back(mk_item(0, 0, 0, 0, 32'h7fffffff));
    directed.push_back(mk_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               32'h7fffffff));
    directed.push_back(mk_item(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                               32'h7fffffff));
    directed.push_back(mk_item(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1));
    directed.push_back(mk_item(65536, 65536, 65536, 0, 4 * 65536));
    directed.push_back(mk_item(3 * 65536, 4 * 65536, 65536, 0, 5 * 65536));
    directed.push_back(mk_item(65536, 65536, 65536 + 10, 65536 - 10, 65536));
    directed.push_back(mk_item(20, -30, 2 * 65536, -65536, 65536));
    directed.push_back(mk_item(0, 0, 0, 5 * 65536, 65536));
    directed.push_back(mk_item(0, 0, 32'h80000000, 32'h80000000, 32'h7fffffff));
    directed.push_back(mk_item(65536, 0, 0, 3 * 65536, 2 * 65536));
    directed.push_back(mk_item(-65536, 65536, 5 * 65536, -2 * 65536, 3 * 65536));
    directed.push_back(mk_item(32'h40000000, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    directed.push_back(mk_item(0, -65536, 0, 0, 0));
    directed.push_back(mk_item(100, 0, -100, 0, 0));
    directed.push_back(mk_item(65536, 0, -65536 * 4, 0, 2 * 65536));
    foreach (directed[i]) send(directed[i], 1'b0);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 300) begin
        // Let the pipeline drain completely before continuing.
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (i == 700) calm = 1'b1;
      if (i == 1000) calm = 1'b0;
      send(rnd_item(), 1'b1);
    end
    item_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("PASS priority_vector_magnitude_clamp_core");
    end else begin
      $display("FAIL priority_vector_magnitude_clamp_core");
    end
    $finish;
  end

endmodule
